// File: rtl/core/hffa_pkg.sv
// ----------------------------------------------------------------------------
// hffa_pkg: shared types, constants and table function
// Holds the field widths, the queue entry layout, the back-end state
// encoding and the build-time delta form factor function.
// ----------------------------------------------------------------------------
package hffa_pkg;

  localparam int HEMI_RES_DEF     = 128;
  localparam int MAX_ELEMENTS_DEF = 4096;

  localparam int CFG_W       = 13;
  localparam int KIND_W      = 2;
  localparam int PIX_W       = 7;
  localparam int ID_W        = 32;
  localparam int READ_ID_W   = 12;
  localparam int SUM_W       = 34;
  localparam int FACTOR_W    = 32;
  localparam int ADDR_MAX_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [63:0]      INV_PI_Q32 = 64'd1367130551;

  // Input kind codes.
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ACC,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_ACC,
    BK_READ
  } back_state_e;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    op_e                   op;
    logic                  top;
    logic [PIX_W-1:0]      row_idx;
    logic [PIX_W-1:0]      col_idx;
    logic [ADDR_MAX_W-1:0] addr;
    logic [READ_ID_W-1:0]  read_id;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Delta form factor for mirrored indices r and c of a face with half
  // resolution n, rounded half up. Used only to build constant tables.
  function automatic logic [FACTOR_W-1:0] delta_factor(int unsigned n, logic top,
                                                       int unsigned r, int unsigned c);
    logic [63:0] nn;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] s;
    logic [63:0] s2;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    int          b;
    nn  = 64'(n);
    rem = '0;
    quo = '0;
    if (r >= n || c >= n) begin
      return '0;
    end
    p   = 64'd2 * nn - 64'd2 * 64'(c) - 64'd1;
    q   = 64'd2 * nn - 64'd2 * 64'(r) - 64'd1;
    s   = p * p + q * q + 64'd4 * nn * nn;
    s2  = s * s;
    num = top ? (64'd16 * nn * nn * INV_PI_Q32) : (64'd8 * nn * q * INV_PI_Q32);
    num = num + (s2 >> 1);
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= s2) begin
        rem    = rem - s2;
        quo[b] = 1'b1;
      end
    end
    return FACTOR_W'(quo);
  endfunction

endpackage

// File: rtl/core/hffa_front.sv
// ----------------------------------------------------------------------------
// hffa_front: request intake and classification
// Holds the element count register, drops background pixels, off-face pixels,
// out-of-range reads and unused kinds, mirrors coordinates, queues the rest.
// ----------------------------------------------------------------------------
module hffa_front #(
  parameter int HEMI_RES     = hffa_pkg::HEMI_RES_DEF,
  parameter int MAX_ELEMENTS = hffa_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hffa_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hffa_pkg::KIND_W-1:0]   kind_i,
  input  logic                          face_is_top_i,
  input  logic [hffa_pkg::PIX_W-1:0]    pixel_row_i,
  input  logic [hffa_pkg::PIX_W-1:0]    pixel_col_i,
  input  logic [hffa_pkg::ID_W-1:0]     element_id_i,
  input  logic                          q_full_i,
  input  hffa_pkg::back_status_t        bk_status_i,
  output logic                          push_o,
  output hffa_pkg::entry_t              entry_o
);

  localparam int N      = HEMI_RES / 2;
  localparam int ELEM_W = $clog2(MAX_ELEMENTS);

  logic [hffa_pkg::CFG_W-1:0] elem_count_q;
  logic                       accept;
  logic                       in_limit;
  logic                       on_face;
  logic [9:0]                 row_lim;

  // Folds a coordinate onto the lower half of the face.
  function automatic logic [hffa_pkg::PIX_W-1:0] mirror(logic [hffa_pkg::PIX_W-1:0] v);
    logic [9:0] i;
    logic [9:0] m;
    i = 10'(v);
    if (i < 10'(N)) begin
      m = i;
    end else if (i < 10'(2 * N)) begin
      m = 10'(2 * N - 1) - i;
    end else begin
      m = 10'(3 * N - 1) - i;
    end
    return hffa_pkg::PIX_W'(m);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= '0;
    end else if (cfg_we_i) begin
      elem_count_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full_i | bk_status_i.clearing;
  assign accept     = in_valid_i & ~in_stall_o;

  assign row_lim  = face_is_top_i ? 10'(HEMI_RES) : 10'(HEMI_RES / 2);
  assign on_face  = (10'(pixel_col_i) < 10'(HEMI_RES)) && (10'(pixel_row_i) < row_lim);
  assign in_limit = (element_id_i < hffa_pkg::ID_W'(elem_count_q)) &&
                    (element_id_i < hffa_pkg::ID_W'(MAX_ELEMENTS));

  always_comb begin
    entry_o.op      = hffa_pkg::OP_ACC;
    entry_o.top     = face_is_top_i;
    entry_o.row_idx = mirror(pixel_row_i);
    entry_o.col_idx = mirror(pixel_col_i);
    entry_o.addr    = hffa_pkg::ADDR_MAX_W'(element_id_i[ELEM_W-1:0]);
    entry_o.read_id = element_id_i[hffa_pkg::READ_ID_W-1:0];
    push_o          = 1'b0;
    unique case (kind_i)
      hffa_pkg::KIND_CLEAR: begin
        entry_o.op = hffa_pkg::OP_CLEAR;
        push_o     = accept;
      end
      hffa_pkg::KIND_ACC: begin
        entry_o.op = hffa_pkg::OP_ACC;
        push_o     = accept & in_limit & on_face;
      end
      hffa_pkg::KIND_READ: begin
        entry_o.op = hffa_pkg::OP_READ;
        push_o     = accept & (element_id_i < hffa_pkg::ID_W'(MAX_ELEMENTS));
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/hffa_queue.sv
// ----------------------------------------------------------------------------
// hffa_queue: request queue between front and back
// A small first-in first-out buffer of classified requests.
// ----------------------------------------------------------------------------
module hffa_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hffa_pkg::entry_t entry_i,
  input  logic             pop_i,
  output hffa_pkg::entry_t head_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int DEPTH = hffa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hffa_pkg::entry_t   slots_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/core/hffa_back.sv
// ----------------------------------------------------------------------------
// hffa_back: sum store, factor table and result register
// Pops requests, runs the clearing sweep, does the read-add-saturate-write
// of each accumulate and loads read results into the output register.
// ----------------------------------------------------------------------------
module hffa_back #(
  parameter int HEMI_RES     = hffa_pkg::HEMI_RES_DEF,
  parameter int MAX_ELEMENTS = hffa_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hffa_pkg::entry_t                 head_i,
  input  logic                             empty_i,
  output logic                             pop_o,
  output hffa_pkg::back_status_t           status_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [hffa_pkg::READ_ID_W-1:0]   read_id_o,
  output logic [hffa_pkg::SUM_W-1:0]       factor_sum_o,
  output logic                             saturated_o
);

  localparam int N         = HEMI_RES / 2;
  localparam int IDX_W     = $clog2(N);
  localparam int ROM_AW    = 2 * IDX_W + 1;
  localparam int ROM_DEPTH = 1 << ROM_AW;
  localparam int ELEM_W    = $clog2(MAX_ELEMENTS);
  localparam int MEM_W     = hffa_pkg::SUM_W + 1;

  hffa_pkg::back_state_e state_q, state_d;
  logic [ELEM_W-1:0]     clr_ptr_q, clr_ptr_d;
  logic [ELEM_W-1:0]     addr_q;
  logic [ELEM_W-1:0]     head_addr;

  logic [MEM_W-1:0]      sum_mem [MAX_ELEMENTS];
  logic                  mem_we;
  logic [ELEM_W-1:0]     mem_waddr;
  logic [MEM_W-1:0]      mem_wdata;
  logic                  mem_re;
  logic [MEM_W-1:0]      mem_rdata_q;

  logic [hffa_pkg::FACTOR_W-1:0] rom_tbl [ROM_DEPTH];
  logic [ROM_AW-1:0]             rom_addr;
  logic [hffa_pkg::FACTOR_W-1:0] rom_q;
  logic                          rom_re;

  logic [hffa_pkg::SUM_W:0]       acc_sum;
  logic                           load_out;
  logic                           out_valid_q;
  logic [hffa_pkg::READ_ID_W-1:0] rid_q;
  logic [hffa_pkg::READ_ID_W-1:0] out_rid_q;
  logic [hffa_pkg::SUM_W-1:0]     out_sum_q;
  logic                           out_sat_q;

  // Factor table, one entry per face kind and mirrored row and column.
  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    localparam int unsigned CC = k % (1 << IDX_W);
    localparam int unsigned RR = (k / (1 << IDX_W)) % (1 << IDX_W);
    localparam logic        TB = (k / (1 << (2 * IDX_W))) != 0;
    localparam logic [hffa_pkg::FACTOR_W-1:0] FVAL = hffa_pkg::delta_factor(N, TB, RR, CC);
    assign rom_tbl[k] = FVAL;
  end

  assign head_addr = head_i.addr[ELEM_W-1:0];
  assign rom_addr  = {head_i.top, IDX_W'(head_i.row_idx), IDX_W'(head_i.col_idx)};
  assign acc_sum   = {1'b0, mem_rdata_q[hffa_pkg::SUM_W-1:0]} +
                     (hffa_pkg::SUM_W + 1)'(rom_q);

  always_comb begin
    state_d   = state_q;
    clr_ptr_d = clr_ptr_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    rom_re    = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      hffa_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_q;
        if (clr_ptr_q == ELEM_W'(MAX_ELEMENTS - 1)) begin
          clr_ptr_d = '0;
          state_d   = hffa_pkg::BK_IDLE;
        end else begin
          clr_ptr_d = clr_ptr_q + ELEM_W'(1);
        end
      end
      hffa_pkg::BK_IDLE: begin
        if (!empty_i) begin
          unique case (head_i.op)
            hffa_pkg::OP_CLEAR: begin
              pop_o   = 1'b1;
              state_d = hffa_pkg::BK_CLEAR;
            end
            hffa_pkg::OP_ACC: begin
              pop_o   = 1'b1;
              mem_re  = 1'b1;
              rom_re  = 1'b1;
              state_d = hffa_pkg::BK_ACC;
            end
            hffa_pkg::OP_READ: begin
              // A read needs the result register to be free.
              if (!out_valid_q) begin
                pop_o   = 1'b1;
                mem_re  = 1'b1;
                state_d = hffa_pkg::BK_READ;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      hffa_pkg::BK_ACC: begin
        mem_we = 1'b1;
        if (acc_sum >= {1'b0, hffa_pkg::SUM_MAX}) begin
          mem_wdata = {1'b1, hffa_pkg::SUM_MAX};
        end else begin
          mem_wdata = {mem_rdata_q[hffa_pkg::SUM_W], acc_sum[hffa_pkg::SUM_W-1:0]};
        end
        state_d = hffa_pkg::BK_IDLE;
      end
      hffa_pkg::BK_READ: begin
        load_out = 1'b1;
        state_d  = hffa_pkg::BK_IDLE;
      end
      default: begin
        state_d = hffa_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hffa_pkg::BK_CLEAR;
      clr_ptr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_ptr_q <= clr_ptr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sum_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= sum_mem[head_addr];
    end
    if (rom_re) begin
      rom_q <= rom_tbl[rom_addr];
    end
    if (pop_o) begin
      addr_q <= head_addr;
      rid_q  <= head_i.read_id;
    end
    if (load_out) begin
      out_rid_q <= rid_q;
      out_sum_q <= mem_rdata_q[hffa_pkg::SUM_W-1:0];
      out_sat_q <= mem_rdata_q[hffa_pkg::SUM_W];
    end
  end

  assign status_o.clearing = (state_q == hffa_pkg::BK_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign read_id_o         = out_rid_q;
  assign factor_sum_o      = out_sum_q;
  assign saturated_o       = out_sat_q;

endmodule

// File: rtl/core/hemicube_form_factor_accumulator.sv
// ----------------------------------------------------------------------------
// hemicube_form_factor_accumulator: per-element delta form factor sums
// Streams hemicube pixels into per-element Q2.32 sums and reads them back.
// ----------------------------------------------------------------------------
// Usage. Requests enter on in_valid_i/in_stall_o with kind_i selecting a
// clear, an accumulate or a read. The element count register is written
// through cfg_we_i/cfg_wdata_i while the block is idle. Read results leave on
// out_valid_o/out_stall_i; clears and accumulates produce no result.
// The front stage classifies each request in the cycle it is accepted and
// drops background pixels, off-face pixels, out-of-range reads and the
// unused kind. Kept requests wait in a four-entry queue for the back stage.
// An accumulate does a registered sum-store and factor-table read, then the
// saturating add and write, and the back stage takes the next pixel only
// after that write. A read does the same registered sum-store read and then
// loads the result register, which offers the result. A clear sweeps the
// sum store one entry per cycle, and in_stall_o stays high during the sweep.
// After reset the same sweep runs over the whole store before the first
// request is taken. While the receiver stalls, the result register holds
// its value, and a later read waits in the queue; when the queue fills,
// in_stall_o rises.
// ----------------------------------------------------------------------------
module hemicube_form_factor_accumulator #(
  parameter int HEMI_RES     = hffa_pkg::HEMI_RES_DEF,
  parameter int MAX_ELEMENTS = hffa_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hffa_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hffa_pkg::KIND_W-1:0]     kind_i,
  input  logic                            face_is_top_i,
  input  logic [hffa_pkg::PIX_W-1:0]      pixel_row_i,
  input  logic [hffa_pkg::PIX_W-1:0]      pixel_col_i,
  input  logic [hffa_pkg::ID_W-1:0]       element_id_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hffa_pkg::READ_ID_W-1:0]  read_id_o,
  output logic [hffa_pkg::SUM_W-1:0]      factor_sum_o,
  output logic                            saturated_o
);

  // Front to queue.
  logic                   push;
  hffa_pkg::entry_t       push_entry;
  logic                   q_full;

  // Queue to back.
  hffa_pkg::entry_t       head;
  logic                   q_empty;
  logic                   pop;

  // Back status seen by the front; a running sweep holds off new requests.
  hffa_pkg::back_status_t bk_status;

  hffa_front #(
    .HEMI_RES     (HEMI_RES),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .face_is_top_i (face_is_top_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .element_id_i  (element_id_i),
    .q_full_i      (q_full),
    .bk_status_i   (bk_status),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  hffa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  hffa_back #(
    .HEMI_RES     (HEMI_RES),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .status_o     (bk_status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_id_o    (read_id_o),
    .factor_sum_o (factor_sum_o),
    .saturated_o  (saturated_o)
  );

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for hemicube_form_factor_accumulator
// Drives clear, accumulate and read requests with random gaps and result
// stalls, predicts every element sum in step with each accepted request and
// checks each read result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Geometry and arithmetic of the block as configured here.
  localparam int          FACE_RES     = 128;
  localparam int          HALF_RES     = FACE_RES / 2;
  localparam int          ELEMENTS     = 4096;
  localparam longint      RECIP_PI_Q32 = 64'd1367130551;
  localparam logic [33:0] SUM_CEIL     = 34'h3_FFFF_FFFF;

  // The request kind the block decodes as a no-op.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Time allowed for the queue and back stage to settle once nothing is
  // expected any more; a clear sweep is waited out separately on in_stall_o.
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_WAIT     = 14;
  // The slowest correct run is dominated by the clear sweeps over all 4096
  // entries and by the random gaps and result stalls, well under this limit.
  localparam int CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic [11:0] read_id;
    logic [33:0] factor_sum;
    logic        saturated;
  } sum_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [12:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic        face_is_top_i;
  logic [6:0]  pixel_row_i;
  logic [6:0]  pixel_col_i;
  logic [31:0] element_id_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [11:0] read_id_o;
  logic [33:0] factor_sum_o;
  logic        saturated_o;

  // Predicted contents of the sum store and the element count register.
  logic [33:0] elem_sum [ELEMENTS];
  logic        elem_sat [ELEMENTS];
  logic [12:0] live_count;

  // Read results that have been predicted but not yet seen.
  sum_report_t pending_reads[$];

  int  mismatches;
  int  cycle_count;
  int  stall_countdown;
  bit  sender_gaps;
  bit  receiver_stalls;

  hemicube_form_factor_accumulator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .face_is_top_i(face_is_top_i),
    .pixel_row_i  (pixel_row_i),
    .pixel_col_i  (pixel_col_i),
    .element_id_i (element_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_id_o    (read_id_o),
    .factor_sum_o (factor_sum_o),
    .saturated_o  (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block never drains or never accepts a request.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Delta form factor of one pixel, unsigned Q0.32. Rows and columns fold
  // about the face center, so index i and index FACE_RES-1-i share a value.
  // The quotient is rounded half up, exactly as the build-time table is.
  function automatic logic [31:0] pixel_factor(logic top, logic [6:0] row, logic [6:0] col);
    longint unsigned half;
    longint unsigned fold_r;
    longint unsigned fold_c;
    longint unsigned p;
    longint unsigned q;
    longint unsigned s;
    longint unsigned s2;
    longint unsigned num;
    half   = HALF_RES;
    fold_r = (row < half) ? row : half - 1 - (row % half);
    fold_c = (col < half) ? col : half - 1 - (col % half);
    p      = 2 * half - 2 * fold_c - 1;
    q      = 2 * half - 2 * fold_r - 1;
    s      = p * p + q * q + 4 * half * half;
    s2     = s * s;
    // The side faces carry the extra y term, which is q/(2n) here.
    num    = top ? (16 * half * half * RECIP_PI_Q32) : (8 * half * q * RECIP_PI_Q32);
    return 32'((num + s2 / 2) / s2);
  endfunction

  function automatic void zero_sums();
    for (int e = 0; e < ELEMENTS; e++) begin
      elem_sum[e] = '0;
      elem_sat[e] = 1'b0;
    end
  endfunction

  // Applies one accepted request to the predicted store and queues the
  // result it is expected to produce, if any.
  function automatic void apply_request(logic [1:0] kind, logic top, logic [6:0] row,
                                        logic [6:0] col, logic [31:0] id);
    longint unsigned limit;
    logic [34:0]     total;
    sum_report_t     report;
    limit = (live_count < ELEMENTS) ? live_count : ELEMENTS;
    unique case (kind)
      hffa_pkg::KIND_CLEAR: begin
        zero_sums();
      end
      hffa_pkg::KIND_ACC: begin
        // Background pixels and pixels off the face leave the store alone.
        // A side face is only half as tall as the top face.
        if (id < limit && row < (top ? FACE_RES : HALF_RES)) begin
          total = {1'b0, elem_sum[id[11:0]]} + pixel_factor(top, row, col);
          if (total >= {1'b0, SUM_CEIL}) begin
            total = {1'b0, SUM_CEIL};
            elem_sat[id[11:0]] = 1'b1;
          end
          elem_sum[id[11:0]] = total[33:0];
        end
      end
      hffa_pkg::KIND_READ: begin
        // An address past the store gives nothing back, but an address past
        // the live count still returns whatever the entry holds.
        if (id < ELEMENTS) begin
          report.read_id    = id[11:0];
          report.factor_sum = elem_sum[id[11:0]];
          report.saturated  = elem_sat[id[11:0]];
          pending_reads.push_back(report);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Each result waits out a freshly drawn stall before it is taken. While no
  // result is offered the stall line toggles at random, so that a stall can
  // already be up when a result first appears.
  always @(negedge clk_i) begin
    if (out_valid_o && stall_countdown > 0) begin
      out_stall_i = 1'b1;
      stall_countdown--;
    end else begin
      out_stall_i = receiver_stalls && !out_valid_o && ($urandom_range(0, 3) == 0);
    end
  end

  // Compares every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    sum_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_countdown = receiver_stalls ? int'($urandom_range(0, MAX_WAIT)) : 0;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result, expected none, got id %0d sum %0h sat %0b",
                 $time, read_id_o, factor_sum_o, saturated_o);
        mismatches++;
      end else begin
        want = pending_reads.pop_front();
        if (read_id_o !== want.read_id) begin
          $display("%0t: read_id expected %0d, got %0d", $time, want.read_id, read_id_o);
          mismatches++;
        end
        if (factor_sum_o !== want.factor_sum) begin
          $display("%0t: factor_sum of %0d expected %0h, got %0h",
                   $time, want.read_id, want.factor_sum, factor_sum_o);
          mismatches++;
        end
        if (saturated_o !== want.saturated) begin
          $display("%0t: saturated of %0d expected %0b, got %0b",
                   $time, want.read_id, want.saturated, saturated_o);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request after a random gap and holds it until it is taken.
  // Valid stays high on return, so back-to-back requests follow without valid dropping.
  task automatic send_request(logic [1:0] kind, logic top, logic [6:0] row,
                              logic [6:0] col, logic [31:0] id);
    int gap;
    gap = sender_gaps ? int'($urandom_range(0, MAX_WAIT)) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i        = kind;
    face_is_top_i = top;
    pixel_row_i   = row;
    pixel_col_i   = col;
    element_id_i  = id;
    in_valid_i    = 1'b1;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    apply_request(kind, top, row, col, id);
  endtask

  // Holds off new requests until every predicted result has been taken, the
  // back stage has had time to finish any accumulates, and a clear sweep
  // (if one is running) is over.
  task automatic wait_until_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Only ever called with the block idle.
  task automatic write_element_count(logic [12:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    live_count  = value;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corners of both face types, mirrored indices, background ids, pixels off
  // a side face, the unused kind, reads past the store and a clear.
  task automatic test_directed();
    write_element_count(13'd4096);
    send_request(hffa_pkg::KIND_ACC, 1'b1, 7'd0, 7'd0, 32'd0);
    send_request(hffa_pkg::KIND_ACC, 1'b1, 7'd127, 7'd127, 32'd4095);
    send_request(hffa_pkg::KIND_ACC, 1'b1, 7'd63, 7'd64, 32'd2);
    send_request(hffa_pkg::KIND_ACC, 1'b0, 7'd63, 7'd64, 32'd1);
    send_request(hffa_pkg::KIND_ACC, 1'b0, 7'd0, 7'd127, 32'd1);
    send_request(hffa_pkg::KIND_ACC, 1'b0, 7'd64, 7'd10, 32'd1);
    send_request(hffa_pkg::KIND_ACC, 1'b0, 7'd127, 7'd0, 32'd3);
    send_request(hffa_pkg::KIND_ACC, 1'b1, 7'd5, 7'd5, 32'd4096);
    send_request(hffa_pkg::KIND_ACC, 1'b1, 7'd5, 7'd5, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED, 1'b1, 7'd127, 7'd127, 32'd0);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd0);
    send_request(hffa_pkg::KIND_READ, 1'b1, 7'd127, 7'd127, 32'd4095);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd1);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd2);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd3);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd4096);
    send_request(hffa_pkg::KIND_READ, 1'b1, 7'd127, 7'd127, 32'hFFFF_FFFF);
    // The sender pauses here until the reads above have all come back.
    wait_until_idle();
    send_request(hffa_pkg::KIND_CLEAR, 1'b0, 7'd0, 7'd0, 32'd0);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd0);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd4095);
    wait_until_idle();
  endtask

  // The live count at its extremes: zero, one and the largest value the
  // register holds, which is clipped to the store size.
  task automatic test_element_count();
    write_element_count(13'd0);
    send_request(hffa_pkg::KIND_ACC, 1'b1, 7'd64, 7'd64, 32'd0);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd0);
    wait_until_idle();
    write_element_count(13'd1);
    send_request(hffa_pkg::KIND_ACC, 1'b1, 7'd64, 7'd64, 32'd0);
    send_request(hffa_pkg::KIND_ACC, 1'b1, 7'd64, 7'd64, 32'd1);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd0);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd1);
    wait_until_idle();
    write_element_count(13'd8191);
    send_request(hffa_pkg::KIND_ACC, 1'b0, 7'd1, 7'd2, 32'd4095);
    send_request(hffa_pkg::KIND_ACC, 1'b0, 7'd1, 7'd2, 32'd4096);
    send_request(hffa_pkg::KIND_READ, 1'b0, 7'd0, 7'd0, 32'd4095);
    wait_until_idle();
  endtask

  // Mostly accumulates and reads on a small set of hot elements so that
  // sums build up and back-to-back updates of one element are exercised,
  // with background ids, off-face rows, wild addresses, the unused kind and
  // the odd clear mixed in. Each phase runs under a different live count.
  task automatic test_random(int per_phase);
    logic [12:0]     counts[5];
    logic [1:0]      kind;
    logic            top;
    logic [6:0]      row;
    logic [6:0]      col;
    logic [31:0]     id;
    longint unsigned limit;
    int              pick;
    counts = '{13'd4096, 13'($urandom_range(2, 4095)), 13'd16, 13'd8191, 13'd0};
    foreach (counts[ph]) begin
      write_element_count(counts[ph]);
      limit = (live_count < ELEMENTS) ? live_count : ELEMENTS;
      for (int n = 0; n < per_phase; n++) begin
        if (n % 64 == 0) begin
          sender_gaps     = ($urandom_range(0, 3) != 0);
          receiver_stalls = ($urandom_range(0, 3) != 0);
        end
        top  = 1'($urandom_range(0, 1));
        col  = 7'($urandom_range(0, 127));
        row  = (top || $urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
          kind = hffa_pkg::KIND_CLEAR;
        end else if (pick < 58) begin
          kind = hffa_pkg::KIND_ACC;
        end else if (pick < 95) begin
          kind = hffa_pkg::KIND_READ;
        end else begin
          kind = KIND_UNUSED;
        end
        pick = $urandom_range(0, 99);
        if (kind == hffa_pkg::KIND_ACC && limit > 0 && pick < 50) begin
          id = $urandom_range(0, 32'(((limit < 32) ? limit : 32) - 1));
        end else if (kind == hffa_pkg::KIND_ACC && limit > 0 && pick < 85) begin
          id = $urandom_range(0, 32'(limit - 1));
        end else if (kind == hffa_pkg::KIND_READ && pick < 55) begin
          id = $urandom_range(0, 31);
        end else if (pick < 88) begin
          id = $urandom_range(0, 4095);
        end else if (pick < 94) begin
          id = $urandom_range(4096, 8191);
        end else begin
          id = $urandom;
        end
        send_request(kind, top, row, col, id);
      end
      wait_until_idle();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    kind_i          = hffa_pkg::KIND_CLEAR;
    face_is_top_i   = 1'b0;
    pixel_row_i     = '0;
    pixel_col_i     = '0;
    element_id_i    = '0;
    out_stall_i     = 1'b0;
    mismatches      = 0;
    cycle_count     = 0;
    stall_countdown = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    live_count      = '0;
    zero_sums();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    // The store is swept clean after reset before the block takes requests.
    wait_until_idle();

    test_directed();
    test_element_count();
    test_random(210);

    wait_until_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/hffa_pkg.sv
rtl/core/hffa_front.sv
rtl/core/hffa_queue.sv
rtl/core/hffa_back.sv
rtl/core/hemicube_form_factor_accumulator.sv
dv/tb.sv
